// File: hdl/lfr_pkg.sv
// Shared types and codes for the link frame receiver.
package lfr_pkg;

    localparam int unsigned LFR_MAX_PAYLOAD = 1024;

    // Line bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] ADDR_TX   = 8'h03;
    localparam logic [7:0] ADDR_RX   = 8'h01;

    // Control codes
    localparam logic [7:0] CODE_SET  = 8'h03;
    localparam logic [7:0] CODE_UA   = 8'h07;
    localparam logic [7:0] CODE_RR0  = 8'h05;
    localparam logic [7:0] CODE_RR1  = 8'h85;
    localparam logic [7:0] CODE_REJ0 = 8'h01;
    localparam logic [7:0] CODE_REJ1 = 8'h81;
    localparam logic [7:0] CODE_I0   = 8'h00;
    localparam logic [7:0] CODE_I1   = 8'h40;
    localparam logic [7:0] CODE_DISC = 8'h0B;

    // Expected-frame modes
    localparam logic [2:0] MODE_SET  = 3'd0;
    localparam logic [2:0] MODE_UA   = 3'd1;
    localparam logic [2:0] MODE_RR   = 3'd2;
    localparam logic [2:0] MODE_REJ  = 3'd3;
    localparam logic [2:0] MODE_INFO = 3'd4;
    localparam logic [2:0] MODE_DISC = 3'd5;

    // Frame events
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_ACCEPT   = 2'd1;
    localparam logic [1:0] EV_CHECK    = 2'd2;
    localparam logic [1:0] EV_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_ROLE    = 1'b1;
    localparam int unsigned CFG_DATA_W = 3;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [1:0]  frame_event;
        logic [7:0]  control_code;
        logic [2:0]  mode_now;
        logic [2:0]  receiver_phase;
        logic [10:0] payload_count;
    } t_out_item;

endpackage

// File: hdl/link_frame_receiver_unit.sv
// Link frame receiver: flag/address/control/header check, byte destuffing, XOR check.
//
// Usage:
//   Input channel carries one item per line byte (action, rx_byte); action=1
//   restarts the receiver in the configured initial mode. Every accepted item
//   yields exactly one result item (payload byte if released, frame event,
//   control code, current mode, phase and payload count).
//   The result is registered: it is loaded into the output register at the
//   accepting edge. Throughput is one item per cycle while the output is not
//   stalled; the whole frame state update is one pass of logic feeding the
//   output register.
//   Payload bytes come out one byte late; the last destuffed byte of a frame
//   is compared with the running XOR as the check byte.
//   When the receiver stalls, the output register holds its item and
//   o_in_stall is raised in the same cycle, so no new item is taken until the
//   held result is gone. A new item is taken while the held result is taken.
//   Configuration: write i_cfg_data to register i_cfg_index (0 initial mode,
//   1 peer role) while the block is idle.
//   Reset (i_rst_n low, synchronous) returns to the start phase, mode info,
//   peer role 0, and empties the output register.
module link_frame_receiver_unit
    import lfr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = LFR_MAX_PAYLOAD
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CW:0] MAX_L = (CW + 1)'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_FLAG   = 3'd1,
        PH_ADDR   = 3'd2,
        PH_CTRL   = 3'd3,
        PH_HDR    = 3'd4,
        PH_DATA   = 3'd5,
        PH_HALTED = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [2:0] r_mode, n_mode;
    logic       r_esc, n_esc;
    logic [7:0] r_addr, n_addr;
    logic [7:0] r_ctrl, n_ctrl;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_held, n_held;
    logic       r_held_v, n_held_v;
    logic [CW-1:0] r_count, n_count;

    logic [2:0] r_init_mode;
    logic       r_peer;

    logic       r_out_valid;
    t_out_item  r_out, n_out;

    logic       in_accept;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        logic       take;
        logic [7:0] d;
        logic [7:0] b;
        logic [7:0] want;
        logic       ok;
        logic [1:0] ev;
        logic       pv;
        logic [7:0] pb;

        take = 1'b0;
        d    = 8'h00;
        b    = i_in_data.rx_byte;
        want = ADDR_TX;
        ok   = 1'b0;
        ev   = EV_NONE;
        pv   = 1'b0;
        pb   = 8'h00;

        n_phase  = r_phase;
        n_mode   = r_mode;
        n_esc    = r_esc;
        n_addr   = r_addr;
        n_ctrl   = r_ctrl;
        n_xor    = r_xor;
        n_held   = r_held;
        n_held_v = r_held_v;
        n_count  = r_count;

        if (i_in_data.action) begin
            n_phase  = PH_START;
            n_mode   = r_init_mode;
            n_esc    = 1'b0;
            n_xor    = 8'h00;
            n_held   = 8'h00;
            n_held_v = 1'b0;
            n_count  = '0;
        end else begin
            unique case (r_phase)
                PH_START: begin
                    if (b == FLAG_BYTE) n_phase = PH_FLAG;
                end
                PH_FLAG: begin
                    if (b != FLAG_BYTE) begin
                        if (r_mode == MODE_DISC && r_peer) want = ADDR_RX;
                        if (b == want) begin
                            n_addr  = b;
                            n_phase = PH_ADDR;
                        end else begin
                            n_phase = PH_START;
                        end
                    end
                end
                PH_ADDR: begin
                    if (b == FLAG_BYTE) begin
                        n_phase = PH_FLAG;
                    end else begin
                        case (r_mode) inside
                            MODE_SET: ok = (b == CODE_SET);
                            MODE_UA:  ok = (b == CODE_UA);
                            MODE_RR, MODE_REJ: begin
                                if (b == CODE_RR0 || b == CODE_RR1) begin
                                    ok = 1'b1;
                                end else if (b == CODE_REJ0 || b == CODE_REJ1) begin
                                    ok     = 1'b1;
                                    n_mode = MODE_REJ;
                                end
                            end
                            MODE_INFO: begin
                                if (b == CODE_I0 || b == CODE_I1) begin
                                    ok = 1'b1;
                                end else if (b == CODE_DISC) begin
                                    ok     = 1'b1;
                                    n_mode = MODE_DISC;
                                end
                            end
                            MODE_DISC: ok = (b == CODE_DISC);
                            default:   ok = 1'b0;
                        endcase
                        if (ok) begin
                            n_ctrl  = b;
                            n_phase = PH_CTRL;
                        end else begin
                            n_phase = PH_START;
                        end
                    end
                end
                PH_CTRL: begin
                    if (b == FLAG_BYTE) begin
                        n_phase = PH_FLAG;
                    end else if (b == (r_addr ^ r_ctrl)) begin
                        n_phase  = PH_HDR;
                        n_esc    = 1'b0;
                        n_xor    = 8'h00;
                        n_held   = 8'h00;
                        n_held_v = 1'b0;
                        n_count  = '0;
                    end else begin
                        n_phase = PH_START;
                    end
                end
                PH_HDR: begin
                    if (r_mode == MODE_INFO) begin
                        if (b == FLAG_BYTE) begin
                            n_phase = PH_START;
                        end else begin
                            // escape and hold are clear here, so a plain byte is held
                            n_phase = PH_DATA;
                            if (b == ESC_BYTE) begin
                                n_esc = 1'b1;
                            end else begin
                                take = 1'b1;
                                d    = b;
                            end
                        end
                    end else if (r_mode <= MODE_DISC) begin
                        if (b == FLAG_BYTE) begin
                            n_phase = PH_DONE;
                            ev      = EV_ACCEPT;
                        end else begin
                            n_phase = PH_START;
                        end
                    end else begin
                        n_phase = PH_START;
                    end
                end
                PH_DATA: begin
                    if (({1'b0, r_count} + (CW + 1)'(r_held_v)) >= MAX_L) begin
                        n_phase  = PH_START;
                        ev       = EV_OVERFLOW;
                        n_esc    = 1'b0;
                        n_held_v = 1'b0;
                    end else if (b == FLAG_BYTE) begin
                        n_esc = 1'b0;
                        if (r_held_v && r_held == r_xor) begin
                            n_phase  = PH_DONE;
                            ev       = EV_ACCEPT;
                            n_held_v = 1'b0;
                        end else begin
                            n_phase = PH_HALTED;
                            n_mode  = MODE_REJ;
                            ev      = EV_CHECK;
                        end
                    end else if (r_esc) begin
                        take  = 1'b1;
                        d     = b ^ ESC_XOR;
                        n_esc = 1'b0;
                    end else if (b == ESC_BYTE) begin
                        n_esc = 1'b1;
                    end else begin
                        take = 1'b1;
                        d    = b;
                    end
                end
                PH_HALTED: begin
                end
                PH_DONE: begin
                    n_phase  = PH_START;
                    n_esc    = 1'b0;
                    n_xor    = 8'h00;
                    n_held   = 8'h00;
                    n_held_v = 1'b0;
                    n_count  = '0;
                end
                default: begin
                end
            endcase
        end

        // release the previously held byte when a new one arrives
        if (take) begin
            if (r_held_v) begin
                pv      = 1'b1;
                pb      = r_held;
                n_xor   = r_xor ^ r_held;
                n_count = r_count + 1'b1;
            end
            n_held   = d;
            n_held_v = 1'b1;
        end

        n_out.payload_valid  = pv;
        n_out.payload_byte   = pb;
        n_out.frame_event    = ev;
        n_out.control_code   = n_ctrl;
        n_out.mode_now       = n_mode;
        n_out.receiver_phase = n_phase;
        n_out.payload_count  = 11'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_mode      <= MODE_INFO;
            r_esc       <= 1'b0;
            r_addr      <= 8'h00;
            r_ctrl      <= 8'h00;
            r_xor       <= 8'h00;
            r_held      <= 8'h00;
            r_held_v    <= 1'b0;
            r_count     <= '0;
            r_init_mode <= MODE_INFO;
            r_peer      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_INITIAL_MODE: r_init_mode <= i_cfg_data;
                    CFG_PEER_ROLE:    r_peer      <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (in_accept) begin
                r_phase     <= n_phase;
                r_mode      <= n_mode;
                r_esc       <= n_esc;
                r_addr      <= n_addr;
                r_ctrl      <= n_ctrl;
                r_xor       <= n_xor;
                r_held      <= n_held;
                r_held_v    <= n_held_v;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

endmodule
